[sv/sha0bsh_pkg.sv]
`default_nettype none

package sha0bsh_pkg;

    // Operation codes of the input channel.
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int ROUNDS       = 80;
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int BLOCK_WORDS  = 16;
    localparam int WIDX_W       = $clog2(BLOCK_WORDS);
    localparam int CHAIN_WORDS  = 5;
    localparam int CHAIN_IDX_W  = $clog2(CHAIN_WORDS);
    localparam int DIGEST_BYTES = 20;
    localparam int OBYTE_W      = $clog2(DIGEST_BYTES);
    localparam int LEN_SHIFT    = 3;

    // Round groups: the first round of groups two, three and four.
    localparam int GROUP2_START = 20;
    localparam int GROUP3_START = 40;
    localparam int GROUP4_START = 60;

    // First word of the block that holds the 64-bit length.
    localparam int LEN_WORD_HI = 14;
    localparam int LEN_WORD_LO = 15;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K_GROUP1 = 32'h5A827999;
    localparam logic [31:0] K_GROUP2 = 32'h6ED9EBA1;
    localparam logic [31:0] K_GROUP3 = 32'h8F1BBCDC;
    localparam logic [31:0] K_GROUP4 = 32'hCA62C1D6;

    localparam logic [CHAIN_WORDS-1:0][31:0] INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

endpackage

`default_nettype wire

[sv/sha0_byte_stream_hasher.sv]
`default_nettype none

// SHA-0 byte stream hasher.
// Input channel (i_in_valid / o_in_ready): each transfer carries one item. With
// i_operation absorb, i_data_byte is packed big-endian into the current block;
// with i_operation finish, the message is padded, its bit length appended and
// the digest produced.
// Output channel (o_out_valid / i_out_ready): after a finish the block sends
// 20 transfers of o_digest_byte, chaining word 0 first and the low byte of each
// word first; o_last_byte marks the twentieth. The block then returns to its
// initial state and accepts the next message.
// Sequence: the byte that completes a 64-byte block starts a compression: the
// 80 rounds on the single shared round unit, then the chaining-word update.
// A finish pushes the pad word, then loads the remaining words of the block
// (up to 15) and compresses it. When the pad falls in word 14 or 15, a further
// block of zeros and the length is loaded and compressed. Then come the 20
// digest bytes, one byte per cycle while i_out_ready is high. o_in_ready is
// low during all of that work. When the receiver stalls, the current digest
// byte holds until taken.
// Reset (i_rst_n low at a clock edge) discards any partial message and loads
// the standard initial chaining values.
module sha0_byte_stream_hasher (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_operation,
    input  wire  [7:0] i_data_byte,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [7:0] o_digest_byte,
    output logic       o_last_byte
);
    import sha0bsh_pkg::*;

    // Control state.
    t_state                             r_state, n_state;
    logic [ROUND_W-1:0]                 r_round, n_round;
    logic [WIDX_W-1:0]                  r_widx, n_widx;
    logic [2:0]                         r_left, n_left;
    logic [31:0]                        r_count, n_count;
    logic                               r_fin, n_fin;
    logic                               r_len_here, n_len_here;
    logic [OBYTE_W-1:0]                 r_obyte, n_obyte;
    logic [CHAIN_WORDS-1:0][31:0]       r_chain, n_chain;

    // Datapath registers.
    logic [31:0]                        r_word, n_word;
    logic [BLOCK_WORDS-1:0][31:0]       r_sched;
    logic [31:0]                        r_a, r_b, r_c, r_d, r_e;
    logic [31:0]                        n_a, n_b, n_c, n_d, n_e;

    // Shift line control: one word enters at the top per push.
    logic                               w_push;
    logic [31:0]                        w_push_word;

    logic [2:0]                         w_left_eff;
    logic [31:0]                        w_full_word;
    logic [31:0]                        w_pad_word;
    logic [31:0]                        w_sched_word;
    logic [31:0]                        w_f;
    logic [31:0]                        w_k;
    logic [31:0]                        w_temp;
    logic [31:0]                        w_len_word;
    logic [31:0]                        w_out_word;
    logic                               w_in_fire;
    logic                               w_out_fire;
    logic                               w_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = o_out_valid && i_out_ready;
    assign w_last      = (r_obyte == OBYTE_W'(DIGEST_BYTES - 1));

    // A bytes-left count outside one to four never arises; it is treated as four.
    assign w_left_eff  = (r_left >= 3'd1 && r_left <= 3'd4) ? r_left : 3'd4;
    assign w_full_word = {r_word[23:0], i_data_byte};

    // Pad byte after the bytes already in the word, zeros below it.
    always_comb begin
        case (w_left_eff)
            3'd1:    w_pad_word = {r_word[23:0], PAD_BYTE};
            3'd2:    w_pad_word = {r_word[15:0], PAD_BYTE, 8'h00};
            3'd3:    w_pad_word = {r_word[7:0], PAD_BYTE, 16'h0000};
            default: w_pad_word = {PAD_BYTE, 24'h000000};
        endcase
    end

    // Length words and zero fill of the final padded block.
    always_comb begin
        w_len_word = 32'h0;
        if (r_len_here) begin
            if (r_widx == WIDX_W'(LEN_WORD_HI)) begin
                w_len_word = {29'h0, r_count[31:32-LEN_SHIFT]};
            end else if (r_widx == WIDX_W'(LEN_WORD_LO)) begin
                w_len_word = {r_count[31-LEN_SHIFT:0], {LEN_SHIFT{1'b0}}};
            end
        end
    end

    // Message schedule without the rotate: in the first 16 rounds the oldest word
    // of the shift line is the word of this round, later the XOR of four of its words.
    assign w_sched_word = (r_round < ROUND_W'(BLOCK_WORDS)) ? r_sched[0]
                        : (r_sched[0] ^ r_sched[2] ^ r_sched[8] ^ r_sched[13]);

    always_comb begin
        if (r_round < ROUND_W'(GROUP2_START)) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_GROUP1;
        end else if (r_round < ROUND_W'(GROUP3_START)) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_GROUP2;
        end else if (r_round < ROUND_W'(GROUP4_START)) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_GROUP3;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_GROUP4;
        end
    end

    assign w_temp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_sched_word + w_k;

    assign w_out_word = r_chain[r_obyte[OBYTE_W-1:2]];

    always_comb begin
        case (r_obyte[1:0])
            2'd0:    o_digest_byte = w_out_word[7:0];
            2'd1:    o_digest_byte = w_out_word[15:8];
            2'd2:    o_digest_byte = w_out_word[23:16];
            default: o_digest_byte = w_out_word[31:24];
        endcase
    end

    assign o_last_byte = w_last;

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_widx      = r_widx;
        n_left      = r_left;
        n_count     = r_count;
        n_fin       = r_fin;
        n_len_here  = r_len_here;
        n_obyte     = r_obyte;
        n_chain     = r_chain;
        n_word      = r_word;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_e         = r_e;
        w_push      = 1'b0;
        w_push_word = w_len_word;

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (i_operation == OP_ABSORB) begin
                        n_count = r_count + 32'd1;
                        n_word  = w_full_word;
                        n_left  = w_left_eff - 3'd1;
                        if (w_left_eff == 3'd1) begin
                            n_left      = 3'd4;
                            w_push      = 1'b1;
                            w_push_word = w_full_word;
                            n_widx      = r_widx + WIDX_W'(1);
                            if (r_widx == WIDX_W'(BLOCK_WORDS - 1)) begin
                                n_state = ST_ROUND;
                            end
                        end
                    end else begin
                        w_push      = 1'b1;
                        w_push_word = w_pad_word;
                        n_fin       = 1'b1;
                        n_len_here  = (r_widx < WIDX_W'(LEN_WORD_HI));
                        n_widx      = r_widx + WIDX_W'(1);
                        n_state     = (r_widx == WIDX_W'(BLOCK_WORDS - 1)) ? ST_ROUND
                                                                            : ST_PAD;
                    end
                end
            end

            ST_PAD: begin
                w_push = 1'b1;
                n_widx = r_widx + WIDX_W'(1);
                if (r_widx == WIDX_W'(BLOCK_WORDS - 1)) begin
                    n_state = ST_ROUND;
                end
            end

            ST_ROUND: begin
                w_push      = 1'b1;
                w_push_word = w_sched_word;
                n_a         = w_temp;
                n_b         = r_a;
                n_c         = {r_b[1:0], r_b[31:2]};
                n_d         = r_c;
                n_e         = r_d;
                n_round     = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(ROUNDS - 1)) begin
                    n_round = '0;
                    n_state = ST_FOLD;
                end
            end

            ST_FOLD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_chain[4] = r_chain[4] + r_e;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_len_here) begin
                    n_state = ST_OUT;
                end else begin
                    // Pad landed in word 14 or 15: one more block of zeros and length.
                    n_len_here = 1'b1;
                    n_state    = ST_PAD;
                end
            end

            ST_OUT: begin
                if (w_out_fire) begin
                    n_obyte = r_obyte + OBYTE_W'(1);
                    if (w_last) begin
                        n_obyte    = '0;
                        n_chain    = INIT_CHAIN;
                        n_widx     = '0;
                        n_left     = 3'd4;
                        n_count    = 32'h0;
                        n_fin      = 1'b0;
                        n_len_here = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Working variables start from the chaining words at the first round.
        if (n_state == ST_ROUND && r_state != ST_ROUND) begin
            n_a = r_chain[0];
            n_b = r_chain[1];
            n_c = r_chain[2];
            n_d = r_chain[3];
            n_e = r_chain[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_round    <= '0;
            r_widx     <= '0;
            r_left     <= 3'd4;
            r_count    <= 32'h0;
            r_fin      <= 1'b0;
            r_len_here <= 1'b0;
            r_obyte    <= '0;
            r_chain    <= INIT_CHAIN;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_widx     <= n_widx;
            r_left     <= n_left;
            r_count    <= n_count;
            r_fin      <= n_fin;
            r_len_here <= n_len_here;
            r_obyte    <= n_obyte;
            r_chain    <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_e    <= n_e;
        if (w_push) begin
            r_sched <= {w_push_word, r_sched[BLOCK_WORDS-1:1]};
        end
    end

    // The two channels are never open at the same time.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest output is valid");

    // A compression always starts on a fresh, fully loaded block.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == '0) |-> (r_widx == '0))
        else $error("rounds started with a partially filled block");

    // The rounds run uninterrupted until the last one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round != ROUND_W'(ROUNDS - 1)) |=>
        (r_state == ST_ROUND && r_round == $past(r_round) + ROUND_W'(1)))
        else $error("round sequence broken");

    // Taking the last digest byte returns the block to its initial state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_last_byte) |=>
        (o_in_ready && r_count == 32'h0 && r_chain == INIT_CHAIN))
        else $error("block not reinitialized after the digest");

    // Digest bytes appear only for a finished message whose length is placed.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_fin && r_len_here))
        else $error("digest output without a completed finish");

endmodule

`default_nettype wire
